// ===== design/i488df_pkg.sv =====
// shared types and constants of the ieee 488.2 block deframer
// register map, status codes, configuration and stage structs
// no dependencies
`timescale 1ns / 1ps

package i488df_pkg;

    // width of the block length counters, 8..30
    localparam int LENGTH_BITS = 30;
    localparam int FRAME_BITS  = 30;
    localparam int ADDR_BITS   = 5;

    // register indexes, byte address is 4 times the index
    localparam logic [2:0] REG_BLOCK_FORMAT = 3'd0;
    localparam logic [2:0] REG_FRAME_BYTES  = 3'd1;
    localparam logic [2:0] REG_LIVE_DISCARD = 3'd2;
    localparam logic [2:0] REG_NEW_PROTOCOL = 3'd3;
    localparam logic [2:0] REG_VERT_REF     = 3'd4;
    localparam logic [2:0] REG_GAIN         = 3'd5;
    localparam logic [2:0] REG_OFFSET       = 3'd6;

    // result status codes
    localparam logic [1:0] STATUS_DATA       = 2'd0;
    localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
    localparam logic [1:0] STATUS_SHORT      = 2'd2;

    typedef struct packed {
        logic                   block_format;
        logic [FRAME_BITS-1:0]  frame_bytes;
        logic                   live_discard;
        logic                   new_protocol;
        logic [7:0]             vert_ref;
        logic [23:0]            gain;
        logic signed [31:0]     offset;
    } cfg_t;

    // parser product (code-ref) or (128-code) * gain, before offset
    typedef struct packed {
        logic                valid;
        logic [7:0]          code;
        logic signed [32:0]  product;
        logic                last;
        logic [1:0]          status;
    } mid_t;

endpackage

// ===== design/i488df_parser.sv =====
// header parser and data byte scaling multiply of the block deframer
// holds the framing state and the middle pipeline register
// depends on i488df_pkg
`timescale 1ns / 1ps

module i488df_parser
    import i488df_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic        advance,
    output mid_t        mid
);

    localparam logic [2:0] PH_WAIT_HASH = 3'd0;
    localparam logic [2:0] PH_HUNT      = 3'd1;
    localparam logic [2:0] PH_COUNT     = 3'd2;
    localparam logic [2:0] PH_LENGTH    = 3'd3;
    localparam logic [2:0] PH_DATA      = 3'd4;
    localparam logic [2:0] PH_TRAILER   = 3'd5;
    localparam logic [2:0] PH_DISCARD   = 3'd6;

    localparam int ACC_BITS = LENGTH_BITS + 4;
    localparam logic [FRAME_BITS-1:0] LEN_MAX_F =
        FRAME_BITS'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    logic [2:0]             phase_reg, phase_next;
    logic [3:0]             digits_left_reg, digits_left_next;
    logic [LENGTH_BITS-1:0] length_accum_reg, length_accum_next;
    logic [LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    mid_t                   mid_reg, mid_next;

    logic [7:0]             digit;
    logic [ACC_BITS-1:0]    acc;
    logic [LENGTH_BITS-1:0] raw_len;
    logic [LENGTH_BITS-1:0] len_now;
    logic [3:0]             digits_dec;
    logic signed [8:0]      diff;
    logic signed [32:0]     product;
    logic                   data_last;
    logic [LENGTH_BITS-1:0] data_left;

    assign digit = in_byte - CHAR_ZERO;
    assign acc   = {1'b0, length_accum_reg, 3'b000}
                   + {3'b000, length_accum_reg, 1'b0}
                   + {{(ACC_BITS-4){1'b0}}, digit[3:0]};
    assign len_now    = acc[LENGTH_BITS-1:0];
    assign digits_dec = (digits_left_reg != 4'd0) ? digits_left_reg - 4'd1 : 4'd0;

    always_comb begin
        if (cfg.frame_bytes == '0) begin
            raw_len = LEN_ONE;
        end else if (cfg.frame_bytes > LEN_MAX_F) begin
            raw_len = '1;
        end else begin
            raw_len = cfg.frame_bytes[LENGTH_BITS-1:0];
        end
    end

    // data byte handling shared by header and raw blocks
    always_comb begin
        logic [LENGTH_BITS-1:0] left;
        left = (phase_reg == PH_DATA) ? bytes_left_reg : raw_len;
        data_last = (left <= LEN_ONE);
        data_left = left - LEN_ONE;
    end

    always_comb begin
        if (cfg.new_protocol) begin
            diff = $signed({1'b0, in_byte}) - $signed({1'b0, cfg.vert_ref});
        end else begin
            diff = 9'sd128 - $signed({1'b0, in_byte});
        end
        product = 33'(diff) * $signed({9'b0, cfg.gain});
    end

    always_comb begin
        logic has_result;
        logic take_data;
        phase_next        = phase_reg;
        digits_left_next  = digits_left_reg;
        length_accum_next = length_accum_reg;
        bytes_left_next   = bytes_left_reg;
        has_result        = 1'b0;
        take_data         = 1'b0;
        mid_next.status   = STATUS_DATA;
        unique case (phase_reg)
            PH_COUNT: begin
                if (in_byte < CHAR_ONE || in_byte > CHAR_NINE) begin
                    has_result      = 1'b1;
                    mid_next.status = STATUS_BAD_HEADER;
                end else begin
                    digits_left_next  = digit[3:0];
                    length_accum_next = '0;
                    phase_next        = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (in_byte < CHAR_ZERO || in_byte > CHAR_NINE
                        || acc[ACC_BITS-1:LENGTH_BITS] != '0) begin
                    has_result      = 1'b1;
                    mid_next.status = STATUS_BAD_HEADER;
                end else if (digits_dec != 4'd0) begin
                    length_accum_next = len_now;
                    digits_left_next  = digits_dec;
                end else begin
                    // last length digit closes the header
                    digits_left_next  = 4'd0;
                    length_accum_next = '0;
                    if (cfg.live_discard
                            && FRAME_BITS'(len_now) < cfg.frame_bytes) begin
                        has_result      = 1'b1;
                        mid_next.status = STATUS_SHORT;
                        bytes_left_next = len_now;
                        phase_next      = (len_now != '0) ? PH_DISCARD : PH_TRAILER;
                    end else if (len_now == '0) begin
                        bytes_left_next = '0;
                        phase_next      = cfg.new_protocol ? PH_TRAILER : PH_WAIT_HASH;
                    end else begin
                        bytes_left_next = len_now;
                        phase_next      = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                take_data = 1'b1;
            end
            PH_TRAILER: begin
                phase_next = PH_WAIT_HASH;
            end
            PH_DISCARD: begin
                bytes_left_next = (bytes_left_reg != '0) ? bytes_left_reg - LEN_ONE : '0;
                if (bytes_left_next == '0) begin
                    phase_next = PH_TRAILER;
                end
            end
            default: begin
                // block start, waiting for hash or hunting
                if (!cfg.block_format) begin
                    take_data = 1'b1;
                end else if (in_byte == CHAR_HASH) begin
                    phase_next        = PH_COUNT;
                    digits_left_next  = 4'd0;
                    length_accum_next = '0;
                end else if (phase_reg != PH_HUNT) begin
                    has_result      = 1'b1;
                    mid_next.status = STATUS_BAD_HEADER;
                end
            end
        endcase

        if (has_result && mid_next.status == STATUS_BAD_HEADER) begin
            phase_next        = PH_HUNT;
            digits_left_next  = 4'd0;
            length_accum_next = '0;
        end

        if (take_data) begin
            has_result = 1'b1;
            if (data_last) begin
                bytes_left_next = '0;
                phase_next      = cfg.new_protocol ? PH_TRAILER : PH_WAIT_HASH;
            end else begin
                bytes_left_next = data_left;
                phase_next      = PH_DATA;
            end
        end

        mid_next.valid   = in_valid && has_result;
        mid_next.code    = take_data ? in_byte : 8'd0;
        mid_next.product = product;
        mid_next.last    = take_data && data_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_WAIT_HASH;
            digits_left_reg  <= 4'd0;
            length_accum_reg <= '0;
            bytes_left_reg   <= '0;
            mid_reg.valid    <= 1'b0;
        end else if (advance) begin
            mid_reg.valid <= mid_next.valid;
            if (in_valid) begin
                phase_reg        <= phase_next;
                digits_left_reg  <= digits_left_next;
                length_accum_reg <= length_accum_next;
                bytes_left_reg   <= bytes_left_next;
            end
        end
        if (advance) begin
            mid_reg.code    <= mid_next.code;
            mid_reg.product <= mid_next.product;
            mid_reg.last    <= mid_next.last;
            mid_reg.status  <= mid_next.status;
        end
    end

    assign mid = mid_reg;

endmodule

// ===== design/i488df_scaler.sv =====
// offset subtract, saturation and output register of the block deframer
// depends on i488df_pkg
`timescale 1ns / 1ps

module i488df_scaler
    import i488df_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic signed [31:0] offset,
    input  mid_t         mid,
    input  logic         advance,
    output logic         m_tvalid,
    output logic [39:0]  m_tdata,
    output logic         m_tlast,
    output logic [1:0]   m_tuser
);

    localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
    localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

    logic               valid_reg;
    logic [39:0]        data_reg, data_next;
    logic               last_reg;
    logic [1:0]         user_reg;
    logic signed [33:0] wide;
    logic signed [31:0] value;

    assign wide = 34'(mid.product) - 34'(offset);

    always_comb begin
        if (mid.status != STATUS_DATA) begin
            value = 32'sd0;
        end else if (wide > SAT_MAX) begin
            value = SAT_MAX[31:0];
        end else if (wide < SAT_MIN) begin
            value = SAT_MIN[31:0];
        end else begin
            value = wide[31:0];
        end
        data_next = {value, mid.code};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= mid.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
            last_reg <= mid.last;
            user_reg <= mid.status;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

// ===== design/ieee488_block_deframer.sv =====
// top level of the ieee 488.2 definite-length block deframer
// register port, input register and the two processing stages
// depends on i488df_pkg, i488df_parser, i488df_scaler
`timescale 1ns / 1ps

// Deframes IEEE 488.2 definite-length arbitrary blocks from a byte stream
// ('#', a count digit 1-9, that many decimal length digits, then the data
// bytes, plus one dropped trailer byte with new_protocol set) and turns each
// data byte into a result holding the raw code and a saturated Q16.16
// voltage. With block_format cleared every frame_bytes bytes form a block
// with no header. A malformed header gives one result with status 1 and the
// deframer then skips up to the next '#'; with live_discard set a block
// shorter than frame_bytes gives one status 2 result and its bytes are
// swallowed. The block takes one byte per clock, back to back, while the result
// side is not stalled: a byte goes through an input register, the parser stage
// (framing state update and the code times gain multiply) and the scaler stage
// (offset subtract and saturation into the output register) before its result
// shows on m_tvalid, and bytes that give no result simply vanish.
// Stalls on the result side back up stage by stage, so empty stages keep
// taking bytes while a result waits. The user must write the registers through
// the register port only while the stream is idle; the block does not enforce it.

module ieee488_block_deframer
    import i488df_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // input stream, s_tdata: rx_byte [7:0]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,

    // result stream, m_tdata: sample_code [7:0], sample_value [39:8]
    // m_tlast: last_in_block, m_tuser: status [1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,
    output logic                 m_tlast,
    output logic [1:0]           m_tuser,

    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    mid_t       mid;
    logic       out_ok;
    logic       mid_ok;
    logic       in_ok;
    logic       cfg_write;
    logic [2:0] reg_index;

    // handshake chain, each stage moves when the one after it has room
    assign out_ok   = !m_tvalid || m_tready;
    assign mid_ok   = !mid.valid || out_ok;
    assign in_ok    = !in_valid_reg || mid_ok;
    assign s_tready = in_ok;

    // register write at the access cycle
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_format <= 1'b1;
            cfg_reg.frame_bytes  <= FRAME_BITS'(1400);
            cfg_reg.live_discard <= 1'b0;
            cfg_reg.new_protocol <= 1'b1;
            cfg_reg.vert_ref     <= 8'd127;
            cfg_reg.gain         <= 24'd65536;
            cfg_reg.offset       <= 32'sd0;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_BLOCK_FORMAT: cfg_reg.block_format <= pwdata[0];
                REG_FRAME_BYTES:  cfg_reg.frame_bytes  <= pwdata[FRAME_BITS-1:0];
                REG_LIVE_DISCARD: cfg_reg.live_discard <= pwdata[0];
                REG_NEW_PROTOCOL: cfg_reg.new_protocol <= pwdata[0];
                REG_VERT_REF:     cfg_reg.vert_ref     <= pwdata[7:0];
                REG_GAIN:         cfg_reg.gain         <= pwdata[23:0];
                REG_OFFSET:       cfg_reg.offset       <= $signed(pwdata);
                default: begin
                    // address beyond the register map, write ignored
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_index)
            REG_BLOCK_FORMAT: prdata = {31'd0, cfg_reg.block_format};
            REG_FRAME_BYTES:  prdata = {{(32-FRAME_BITS){1'b0}}, cfg_reg.frame_bytes};
            REG_LIVE_DISCARD: prdata = {31'd0, cfg_reg.live_discard};
            REG_NEW_PROTOCOL: prdata = {31'd0, cfg_reg.new_protocol};
            REG_VERT_REF:     prdata = {24'd0, cfg_reg.vert_ref};
            REG_GAIN:         prdata = {8'd0, cfg_reg.gain};
            REG_OFFSET:       prdata = cfg_reg.offset;
            default:          prdata = 32'd0;
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ok) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ok) begin
            in_byte_reg <= s_tdata;
        end
    end

    // framing state and multiply
    i488df_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (in_valid_reg),
        .in_byte  (in_byte_reg),
        .advance  (mid_ok),
        .mid      (mid)
    );

    // offset, saturation and result register
    i488df_scaler u_scaler (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .offset   (cfg_reg.offset),
        .mid      (mid),
        .advance  (out_ok),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== sim/tb_ieee488_block_deframer.sv =====
// self-checking testbench for the ieee 488.2 block deframer
// directed table then random framed traffic, checked against an in-bench predictor
// depends on i488df_pkg and ieee488_block_deframer
`timescale 1ns / 1ps

module tb_ieee488_block_deframer
    import i488df_pkg::*;
();

    // run limits
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;     // pipeline is three deep
    localparam int LONG_HOLD    = 300;    // receiver hold-off that backs the block up
    localparam int BURST_ITEMS  = 58;     // items per random burst

    // stream characters
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LF   = 8'h0A;

    localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS) - 1;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    // deframer phases
    typedef enum logic [2:0] {
        ST_WAIT_HASH, ST_HUNT, ST_COUNT, ST_LENGTH, ST_DATA, ST_TRAILER, ST_DISCARD
    } deframe_phase_e;

    // how a stimulus row is checked
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RESULT} row_check_e;

    typedef struct packed {
        logic [7:0]         code;
        logic signed [31:0] value;
        logic               last;
        logic [1:0]         status;
    } sample_t;

    typedef struct packed {
        logic [7:0] rx;
        row_check_e chk;
        sample_t    want;
    } tx_item_t;

    localparam sample_t NO_SAMPLE  = '0;
    localparam sample_t BAD_HEADER = '{8'd0, 32'sd0, 1'b0, STATUS_BAD_HEADER};

    // directed part, runs under the reset configuration
    // (new protocol, reference 127, gain 1.0, no offset, no live discard)
    localparam int N_DIRECTED = 27;
    localparam tx_item_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h41,   CHK_RESULT, BAD_HEADER},   // no hash where a block starts
        '{8'h00,   CHK_NONE,   NO_SAMPLE},    // skipped while hunting
        '{CH_HASH, CHK_NONE,   NO_SAMPLE},
        '{8'h31,   CHK_NONE,   NO_SAMPLE},    // one length digit
        '{8'h33,   CHK_NONE,   NO_SAMPLE},    // length 3
        '{8'h00,   CHK_RESULT, '{8'h00, -32'sd8323072, 1'b0, STATUS_DATA}},  // lowest code
        '{8'hFF,   CHK_RESULT, '{8'hFF, 32'sd8388608, 1'b0, STATUS_DATA}},   // highest code
        '{8'h80,   CHK_MODEL,  NO_SAMPLE},    // last data byte
        '{CH_LF,   CHK_NONE,   NO_SAMPLE},    // trailer dropped
        '{CH_HASH, CHK_NONE,   NO_SAMPLE},
        '{8'h30,   CHK_RESULT, BAD_HEADER},   // count digit zero
        '{8'hFF,   CHK_NONE,   NO_SAMPLE},    // hunting
        '{CH_HASH, CHK_NONE,   NO_SAMPLE},
        '{8'h3A,   CHK_RESULT, BAD_HEADER},   // count digit above nine
        '{CH_HASH, CHK_NONE,   NO_SAMPLE},
        '{8'h32,   CHK_NONE,   NO_SAMPLE},
        '{8'h30,   CHK_NONE,   NO_SAMPLE},
        '{8'h30,   CHK_NONE,   NO_SAMPLE},    // zero length, empty block
        '{CH_HASH, CHK_NONE,   NO_SAMPLE},    // its trailer, even a hash is dropped
        '{CH_HASH, CHK_NONE,   NO_SAMPLE},
        '{8'h31,   CHK_NONE,   NO_SAMPLE},
        '{8'h2F,   CHK_RESULT, BAD_HEADER},   // length byte below '0'
        '{CH_HASH, CHK_NONE,   NO_SAMPLE},
        '{8'h31,   CHK_NONE,   NO_SAMPLE},
        '{8'h31,   CHK_NONE,   NO_SAMPLE},    // length 1
        '{8'h7F,   CHK_MODEL,  NO_SAMPLE},    // code at the reference, single byte block
        '{CH_LF,   CHK_NONE,   NO_SAMPLE}
    };

    // dut signals, every input known from time zero
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;
    logic                 m_tlast;
    logic [1:0]           m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_BITS-1:0] paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // predictor copy of the registers and framing state, at reset values
    cfg_t cfg = '{1'b1, 30'd1400, 1'b0, 1'b1, 8'd127, 24'd65536, 32'sd0};
    deframe_phase_e         ph           = ST_WAIT_HASH;
    logic [3:0]             digits_left  = '0;
    logic [LENGTH_BITS-1:0] length_accum = '0;
    logic [LENGTH_BITS-1:0] bytes_left   = '0;

    tx_item_t tx_bytes[$];          // items waiting to be offered
    tx_item_t cur_item;             // item on the input port
    sample_t  pending_samples[$];   // results still owed by the block

    bit in_taken      = 1'b0;
    int fail_count    = 0;
    int samples_seen  = 0;
    int cycle_count   = 0;
    int queued_total  = 0;

    // sender and receiver idling state
    int gap_left = 0, burst_left = 0;
    int stall_left = 0, calm_left = 0, hold_left = 0;
    int next_hold_at = 20;

    ieee488_block_deframer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // ---------------- predictor ----------------

    // (code - ref) * gain - offset, or (128 - code) * gain - offset, saturated
    function automatic logic signed [31:0] to_volts(input logic [7:0] code);
        longint diff, v;
        if (cfg.new_protocol)
            diff = longint'(code) - longint'(cfg.vert_ref);
        else
            diff = 64'sd128 - longint'(code);
        v = diff * longint'(cfg.gain) - longint'($signed(cfg.offset));
        if (v > SAT_HI)
            v = SAT_HI;
        else if (v < SAT_LO)
            v = SAT_LO;
        return v[31:0];
    endfunction

    function automatic bit mark_bad_header(output sample_t res);
        ph = ST_HUNT;
        digits_left = '0;
        length_accum = '0;
        res = BAD_HEADER;
        return 1'b1;
    endfunction

    function automatic void close_block();
        bytes_left = '0;
        ph = cfg.new_protocol ? ST_TRAILER : ST_WAIT_HASH;
    endfunction

    function automatic bit take_sample(input logic [7:0] rx, output sample_t res);
        res = '0;
        res.code = rx;
        res.value = to_volts(rx);
        res.last = (bytes_left <= 1);
        res.status = STATUS_DATA;
        if (res.last)
            close_block();
        else
            bytes_left--;
        return 1'b1;
    endfunction

    // advance the deframer by one byte, returns 1 when a result is due
    function automatic bit step_deframer(input logic [7:0] rx, output sample_t res);
        longint unsigned acc;
        logic [7:0] digit;
        logic [LENGTH_BITS-1:0] blen;
        res = '0;
        digit = rx - CH_ZERO;
        case (ph)
            ST_COUNT: begin
                if (rx < CH_ONE || rx > CH_NINE)
                    return mark_bad_header(res);
                digits_left = digit[3:0];
                length_accum = '0;
                ph = ST_LENGTH;
                return 1'b0;
            end
            ST_LENGTH: begin
                if (rx < CH_ZERO || rx > CH_NINE)
                    return mark_bad_header(res);
                acc = longint'(length_accum) * 10 + longint'(digit);
                if (acc > LEN_MAX)
                    return mark_bad_header(res);
                length_accum = acc[LENGTH_BITS-1:0];
                if (digits_left > 0)
                    digits_left--;
                if (digits_left != 0)
                    return 1'b0;
                // header complete
                blen = length_accum;
                length_accum = '0;
                if (cfg.live_discard && blen < cfg.frame_bytes) begin
                    bytes_left = blen;
                    ph = (blen != 0) ? ST_DISCARD : ST_TRAILER;
                    res.status = STATUS_SHORT;
                    return 1'b1;
                end
                if (blen == 0) begin
                    close_block();
                    return 1'b0;
                end
                bytes_left = blen;
                ph = ST_DATA;
                return 1'b0;
            end
            ST_DATA:
                return take_sample(rx, res);
            ST_TRAILER: begin
                ph = ST_WAIT_HASH;
                return 1'b0;
            end
            ST_DISCARD: begin
                if (bytes_left > 0)
                    bytes_left--;
                if (bytes_left == 0)
                    ph = ST_TRAILER;
                return 1'b0;
            end
            default: ;
        endcase
        // a block starts here
        if (!cfg.block_format) begin
            if (cfg.frame_bytes == 0)
                bytes_left = 1;
            else if (longint'(cfg.frame_bytes) > LEN_MAX)
                bytes_left = LEN_MAX[LENGTH_BITS-1:0];
            else
                bytes_left = cfg.frame_bytes;
            ph = ST_DATA;
            return take_sample(rx, res);
        end
        if (rx == CH_HASH) begin
            ph = ST_COUNT;
            digits_left = '0;
            length_accum = '0;
            return 1'b0;
        end
        if (ph == ST_HUNT)
            return 1'b0;
        return mark_bad_header(res);
    endfunction

    // ---------------- input side ----------------

    // new item at the falling edge once the previous one was taken
    always @(negedge aclk) begin : sender
        int r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (tx_bytes.size() > 0) begin
                cur_item = tx_bytes.pop_front();
                s_tdata  <= cur_item.rx;
                s_tvalid <= 1'b1;
                // gap ahead of the next item: mostly none, some short, few long
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 2)
                        burst_left = $urandom_range(30, 100);
                    else if (r < 5)
                        gap_left = $urandom_range(8, 40);
                    else if (r < 30)
                        gap_left = $urandom_range(1, 3);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- result side ----------------

    always @(negedge aclk) begin : receiver
        int r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (samples_seen >= next_hold_at) begin
            // long hold-off so the pipeline fills and s_tready drops
            hold_left = LONG_HOLD;
            next_hold_at = (next_hold_at < 300) ? 300 : 32'h7FFF_FFFF;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left--;
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                calm_left = $urandom_range(30, 120);
                m_tready <= 1'b1;
            end else if (r < 6) begin
                stall_left = $urandom_range(10, 40);
                m_tready <= 1'b0;
            end else if (r < 30) begin
                stall_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- predict and compare at the rising edge ----------------

    always @(posedge aclk) begin : scoreboard
        sample_t pred, got, want;
        bit have;
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) begin
            have = step_deframer(cur_item.rx, pred);
            case (cur_item.chk)
                CHK_MODEL:  if (have) pending_samples.push_back(pred);
                CHK_RESULT: pending_samples.push_back(cur_item.want);
                default: ;
            endcase
        end
        if (aresetn && m_tvalid && m_tready) begin
            samples_seen++;
            got.code   = m_tdata[7:0];
            got.value  = m_tdata[39:8];
            got.last   = m_tlast;
            got.status = m_tuser;
            if (pending_samples.size() == 0) begin
                $error("result with nothing expected: code %0d value %0d status %0d",
                       got.code, got.value, got.status);
                fail_count++;
            end else begin
                want = pending_samples.pop_front();
                if (got.code !== want.code) begin
                    $error("sample_code: expected %0d, got %0d", want.code, got.code);
                    fail_count++;
                end
                if (got.value !== want.value) begin
                    $error("sample_value: expected %0d, got %0d", want.value, got.value);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $error("last_in_block: expected %0d, got %0d", want.last, got.last);
                    fail_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- register port ----------------

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        case (idx)
            REG_BLOCK_FORMAT: cfg.block_format = val[0];
            REG_FRAME_BYTES:  cfg.frame_bytes  = val[FRAME_BITS-1:0];
            REG_LIVE_DISCARD: cfg.live_discard = val[0];
            REG_NEW_PROTOCOL: cfg.new_protocol = val[0];
            REG_VERT_REF:     cfg.vert_ref     = val[7:0];
            REG_GAIN:         cfg.gain         = val[23:0];
            REG_OFFSET:       cfg.offset       = val;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random reference, gain and offset
    task automatic shuffle_scaling();
        write_reg(REG_VERT_REF, $urandom_range(0, 255));
        write_reg(REG_GAIN, $urandom & 32'h00FF_FFFF);
        write_reg(REG_OFFSET, $urandom);
    endtask

    // ---------------- stimulus generation ----------------

    function automatic void queue_byte(input logic [7:0] b);
        tx_bytes.push_back('{b, CHK_MODEL, NO_SAMPLE});
        queued_total++;
    endfunction

    // random byte with the extremes weighted up
    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        b = 8'($urandom);
        while (b >= CH_ZERO && b <= CH_NINE)
            b = 8'($urandom);
        return b;
    endfunction

    // one header block, mostly well formed, some noise and broken headers
    task automatic queue_header_block();
        int r;
        int unsigned blk_len, ndig, d;
        longint unsigned scale;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 4))
                queue_byte(rand_byte());
        end else if (r < 14) begin
            queue_byte(CH_HASH);
            case ($urandom_range(0, 2))
                0: queue_byte($urandom_range(0, 1) ? CH_ZERO : non_digit());
                1: begin
                    queue_byte(CH_ZERO + 8'd2);
                    queue_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                    queue_byte(non_digit());
                end
                default: begin
                    // header cut short, the next hash lands on a length digit
                    queue_byte(CH_ZERO + 8'd3);
                    queue_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                end
            endcase
        end else begin
            r = $urandom_range(0, 99);
            if (r < 80)
                blk_len = $urandom_range(0, 12);
            else if (r < 95)
                blk_len = $urandom_range(13, 40);
            else
                blk_len = $urandom_range(41, 200);
            ndig = 1;
            scale = 10;
            while (blk_len >= scale) begin
                ndig++;
                scale *= 10;
            end
            d = ndig;
            if ($urandom_range(0, 4) == 0)
                d = $urandom_range(ndig, 9);   // leading zeros
            queue_byte(CH_HASH);
            queue_byte(CH_ZERO + 8'(d));
            scale = 1;
            repeat (d - 1)
                scale *= 10;
            repeat (d) begin
                queue_byte(CH_ZERO + 8'((blk_len / scale) % 10));
                scale /= 10;
            end
            repeat (blk_len)
                queue_byte(rand_byte());
            if (cfg.new_protocol || (cfg.live_discard && blk_len < cfg.frame_bytes))
                queue_byte($urandom_range(0, 1) ? CH_LF : rand_byte());
        end
    endtask

    // wait until the block is drained and quiet
    task automatic settle();
        while (tx_bytes.size() != 0 || s_tvalid || pending_samples.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES)
            @(posedge aclk);
    endtask

    task automatic run_burst(input int n_items);
        int stop_at;
        stop_at = queued_total + n_items;
        while (queued_total < stop_at) begin
            if (cfg.block_format)
                queue_header_block();
            else
                queue_byte(rand_byte());
        end
        settle();
    endtask

    // ---------------- test sequence ----------------

    initial begin : stimulus
        repeat (7)
            @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table under reset configuration
        foreach (DIRECTED_ROWS[i])
            tx_bytes.push_back(DIRECTED_ROWS[i]);
        settle();

        // reset configuration, random blocks
        run_burst(BURST_ITEMS);

        // old protocol, full gain, offset at its most negative
        write_reg(REG_NEW_PROTOCOL, 32'd0);
        write_reg(REG_GAIN, 32'h00FF_FFFF);
        write_reg(REG_OFFSET, 32'h8000_0000);
        run_burst(BURST_ITEMS);

        // new protocol, top reference, offset at its most positive
        write_reg(REG_NEW_PROTOCOL, 32'd1);
        write_reg(REG_VERT_REF, 32'd255);
        write_reg(REG_OFFSET, 32'h7FFF_FFFF);
        run_burst(BURST_ITEMS);

        // live discard against a small frame, old protocol
        shuffle_scaling();
        write_reg(REG_LIVE_DISCARD, 32'd1);
        write_reg(REG_FRAME_BYTES, 32'd6);
        write_reg(REG_NEW_PROTOCOL, 32'd0);
        write_reg(REG_VERT_REF, 32'd0);
        run_burst(BURST_ITEMS);

        // live discard, new protocol
        shuffle_scaling();
        write_reg(REG_FRAME_BYTES, 32'd3);
        write_reg(REG_NEW_PROTOCOL, 32'd1);
        run_burst(BURST_ITEMS);

        // frame of 999999999 bytes, every header block is short
        write_reg(REG_FRAME_BYTES, 32'd999999999);
        write_reg(REG_GAIN, 32'd0);
        run_burst(BURST_ITEMS);

        // raw format, one byte frames
        shuffle_scaling();
        write_reg(REG_LIVE_DISCARD, 32'd0);
        write_reg(REG_BLOCK_FORMAT, 32'd0);
        write_reg(REG_FRAME_BYTES, 32'd1);
        write_reg(REG_NEW_PROTOCOL, 32'd0);
        run_burst(BURST_ITEMS);

        // raw, zero frame acts as one, trailer after every block
        shuffle_scaling();
        write_reg(REG_LIVE_DISCARD, 32'd1);
        write_reg(REG_FRAME_BYTES, 32'd0);
        write_reg(REG_NEW_PROTOCOL, 32'd1);
        run_burst(BURST_ITEMS);

        // raw, seven byte frames
        shuffle_scaling();
        write_reg(REG_LIVE_DISCARD, 32'd0);
        write_reg(REG_FRAME_BYTES, 32'd7);
        write_reg(REG_NEW_PROTOCOL, 32'd0);
        run_burst(BURST_ITEMS);

        // back to header blocks
        shuffle_scaling();
        write_reg(REG_BLOCK_FORMAT, 32'd1);
        write_reg(REG_FRAME_BYTES, 32'd1400);
        write_reg(REG_NEW_PROTOCOL, 32'd1);
        run_burst(BURST_ITEMS);

        // raw with the widest frame, never ends within the run
        shuffle_scaling();
        write_reg(REG_BLOCK_FORMAT, 32'd0);
        write_reg(REG_FRAME_BYTES, 32'h3FFF_FFFF);
        run_burst(BURST_ITEMS);

        if (fail_count == 0 && pending_samples.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/i488df_pkg.sv
design/i488df_parser.sv
design/i488df_scaler.sv
design/ieee488_block_deframer.sv
sim/tb_ieee488_block_deframer.sv
